// ----- rtl/nbs_pkg.sv -----
// Shared types and constants of the 3x3 neighbourhood sum block.
package nbs_pkg;

    // Fixed field widths
    localparam int ROW_W         = 16;
    localparam int FRAME_WIDTH_W = 11;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // Register values after reset
    localparam int RESET_FRAME_WIDTH  = 1024;
    localparam int RESET_FRAME_HEIGHT = 1024;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Position flags of one pixel, worked out when the word is accepted
    typedef struct packed {
        logic r_ge1;     // row 1 or below: line above is valid
        logic r_ge2;     // row 2 or below: line two above is valid
        logic c_zero;    // first column
        logic last_col;  // last column of the row
        logic eof_row;   // flush row after the last image row
    } item_flags_t;

endpackage

// ----- rtl/nbs_line_mem.sv -----
// Line buffer memory: one write port, one read port with registered read data.
module nbs_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write the returned line word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read; hold the data while no new word is accepted
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/nbs_window.sv -----
// Column sum, window sum and result register stage with line buffer write-back.
module nbs_window #(
    parameter int PIXEL_BITS = 16,
    parameter int COL_W      = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  nbs_pkg::item_flags_t           in_flags,
    input  logic [COL_W-1:0]               in_col,
    input  logic [nbs_pkg::ROW_W-1:0]      in_row,
    input  logic signed [PIXEL_BITS-1:0]   in_pixel,
    input  logic [2*PIXEL_BITS-1:0]        rd_data,
    output logic                           wr_en,
    output logic [COL_W-1:0]               wr_addr,
    output logic [2*PIXEL_BITS-1:0]        wr_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [PIXEL_BITS+3:0]   out_sum,
    output logic [nbs_pkg::ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]               out_col,
    output logic                           out_last,
    output logic                           out_eof
);

    import nbs_pkg::*;

    localparam int CS_W  = PIXEL_BITS + 2;
    localparam int SUM_W = PIXEL_BITS + 4;
    localparam int LW_W  = 2 * PIXEL_BITS;

    // Stage registers
    logic                          st_valid_reg;
    logic                          phase_reg;
    item_flags_t                   st_flags_reg;
    logic [COL_W-1:0]              st_col_reg;
    logic [ROW_W-1:0]              st_row_reg;
    logic signed [PIXEL_BITS-1:0]  st_pix_reg;

    // Last written line word, for a read that raced its write
    logic                          fwd_valid_reg;
    logic [COL_W-1:0]              fwd_addr_reg;
    logic [LW_W-1:0]               fwd_data_reg;

    // Running column sums
    logic signed [CS_W-1:0]        col_prev_reg;
    logic signed [CS_W-1:0]        col_prev2_reg;

    // Result register
    logic                          out_valid_reg;
    logic signed [SUM_W-1:0]       out_sum_reg;
    logic [ROW_W-1:0]              out_row_reg;
    logic [COL_W-1:0]              out_col_reg;
    logic                          out_last_reg;
    logic                          out_eof_reg;

    logic [LW_W-1:0]               line_word;
    logic signed [PIXEL_BITS-1:0]  above;
    logic signed [PIXEL_BITS-1:0]  two_above;
    logic signed [CS_W-1:0]        a1_x;
    logic signed [CS_W-1:0]        a2_x;
    logic signed [CS_W-1:0]        col_sum;
    logic signed [CS_W-1:0]        prev_eff;
    logic signed [SUM_W-1:0]       sum_full;
    logic signed [SUM_W-1:0]       sum_edge;
    logic                          need0;
    logic                          need1;
    logic                          emitting;
    logic                          sel_edge;
    logic                          final_res;
    logic                          out_open;
    logic                          push;
    logic                          retire;
    logic                          load;

    // Pick the line word, forwarding the last write to the same column
    assign line_word = (fwd_valid_reg && (fwd_addr_reg == st_col_reg)) ? fwd_data_reg
                                                                       : rd_data;
    assign above     = line_word[PIXEL_BITS-1:0];
    assign two_above = line_word[LW_W-1:PIXEL_BITS];

    // Column total of the current column; rows above the image count as zero
    assign a1_x     = st_flags_reg.r_ge1 ? CS_W'(above) : '0;
    assign a2_x     = st_flags_reg.r_ge2 ? CS_W'(two_above) : '0;
    assign col_sum  = a2_x + a1_x + CS_W'(st_pix_reg);
    assign prev_eff = st_flags_reg.c_zero ? '0 : col_prev_reg;

    // Window sums: full window and the right-edge window
    assign sum_full = SUM_W'(col_prev2_reg) + SUM_W'(prev_eff) + SUM_W'(col_sum);
    assign sum_edge = SUM_W'(prev_eff) + SUM_W'(col_sum);

    // Results this pixel causes
    assign need0     = st_flags_reg.r_ge1 && !st_flags_reg.c_zero;
    assign need1     = st_flags_reg.r_ge1 && st_flags_reg.last_col;
    assign emitting  = phase_reg || need0 || need1;
    assign sel_edge  = phase_reg || !need0;
    assign final_res = phase_reg || !(need0 && need1);

    // Handshake between stage and result register
    assign out_open = !out_valid_reg || out_ready;
    assign push     = st_valid_reg && emitting && out_open;
    assign retire   = st_valid_reg && (!emitting || (push && final_res));
    assign in_ready = !st_valid_reg || retire;
    assign load     = in_valid && in_ready;

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                st_valid_reg <= 1'b0;
            end
            if (retire)
            begin
                phase_reg <= 1'b0;
            end
            else if (push)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_flags_reg <= in_flags;
            st_col_reg   <= in_col;
            st_row_reg   <= in_row;
            st_pix_reg   <= in_pixel;
        end
    end

    // Track the last line write and update the column sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            col_prev_reg  <= '0;
            col_prev2_reg <= '0;
        end
        else if (retire)
        begin
            fwd_valid_reg <= 1'b1;
            col_prev2_reg <= prev_eff;
            col_prev_reg  <= col_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            fwd_addr_reg <= st_col_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // Shift the line: above moves to two above, the pixel becomes above
    assign wr_en   = retire;
    assign wr_addr = st_col_reg;
    assign wr_data = {above, st_pix_reg};

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_sum_reg  <= sel_edge ? sum_edge : sum_full;
            out_row_reg  <= st_row_reg - ROW_W'(1);
            out_col_reg  <= sel_edge ? st_col_reg : st_col_reg - COL_W'(1);
            out_last_reg <= sel_edge || !st_flags_reg.last_col;
            out_eof_reg  <= sel_edge && st_flags_reg.eof_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;
    assign out_eof   = out_eof_reg;

endmodule

// ----- rtl/neighbourhood_sum_3x3.sv -----
// Top level of the 3x3 neighbourhood sum: configuration, pixel position tracking, line memory.
//
// Takes a row-major pixel stream and returns, for each pixel, the signed sum of its 3x3
// neighbourhood with cells outside the image counted as zero. Both line buffers share one
// memory word per column, read when a pixel is accepted and written back when the pixel
// leaves the single stage; a one-column image reuses its word back to back through a
// forwarding register. A pixel is taken every cycle while the output keeps up, except that in
// every row after the first, for an image two or more pixels wide, the last column produces
// two results through the single result register, so such a row stalls the input once at its last pixel.
// The first row of a frame and every row of a one-column image never stall the input this way.
// The result for pixel (r,c) leaves after pixel (r+1,c+1) arrives, or pixel (r+1,c) in the
// last column, so after frame_height rows send one flush row of frame_width words (values
// ignored). A configuration write restarts the frame at pixel (0,0); write only while no
// word is in flight. No clearing pass is run after reset.
module neighbourhood_sum_3x3 #(
    parameter int MAX_WIDTH  = nbs_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nbs_pkg::DEF_PIXEL_BITS,
    parameter int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int S_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((PIXEL_BITS + 4 + nbs_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_W-1:0]               s_tdata,
    // window_sum, out_row, out_col
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,
    // last_in_run
    output logic                               m_tlast,
    // end_of_frame
    output logic                               m_tuser,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import nbs_pkg::*;

    localparam int SUM_W    = PIXEL_BITS + 4;
    localparam int LW_W     = 2 * PIXEL_BITS;
    localparam int WCMP_W   = FRAME_WIDTH_W + 2;
    localparam int RST_WEFF = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
    localparam logic [COL_W-1:0] RST_WLAST = COL_W'(RST_WEFF - 1);

    // Configuration, held as last column index and effective height
    logic [COL_W-1:0]            width_last_reg;
    logic [COL_W-1:0]            width_last_next;
    logic [ROW_W-1:0]            height_reg;
    logic [ROW_W-1:0]            height_next;
    logic [WCMP_W-1:0]           width_ext;

    // Position of the next pixel
    logic [COL_W-1:0]            col_reg;
    logic [ROW_W-1:0]            row_reg;

    logic                        cfg_fire;
    logic                        accept;
    item_flags_t                 flags;
    logic signed [PIXEL_BITS-1:0] pixel_in;
    logic signed [PIXEL_BITS-1:0] pixel_eff;
    logic [LW_W-1:0]             rd_data;
    logic                        wr_en;
    logic [COL_W-1:0]            wr_addr;
    logic [LW_W-1:0]             wr_data;
    logic signed [SUM_W-1:0]     out_sum;
    logic [ROW_W-1:0]            out_row;
    logic [COL_W-1:0]            out_col;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;

    // Clamp the written width and height to the usable range
    assign width_ext = WCMP_W'(cfg_data[FRAME_WIDTH_W-1:0]);

    always_comb
    begin
        width_last_next = width_last_reg;
        height_next     = height_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (width_ext == '0)
                    begin
                        width_last_next = '0;
                    end
                    else if (width_ext > WCMP_W'(MAX_WIDTH))
                    begin
                        width_last_next = COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        width_last_next = COL_W'(width_ext - WCMP_W'(1));
                    end
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = (cfg_data == '0) ? ROW_W'(1) : cfg_data;
                end
                default:
                begin
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg <= RST_WLAST;
            height_reg     <= ROW_W'(RESET_FRAME_HEIGHT);
        end
        else
        begin
            width_last_reg <= width_last_next;
            height_reg     <= height_next;
        end
    end

    // Flags of the pixel at the current position
    assign flags.r_ge1    = (row_reg != '0);
    assign flags.r_ge2    = (row_reg > ROW_W'(1));
    assign flags.c_zero   = (col_reg == '0);
    assign flags.last_col = (col_reg == width_last_reg);
    assign flags.eof_row  = (row_reg == height_reg);

    // Flush row pixels count as zero
    assign pixel_in  = s_tdata[PIXEL_BITS-1:0];
    assign pixel_eff = flags.eof_row ? '0 : pixel_in;

    // Advance the position; restart the frame on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_fire)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (flags.last_col)
            begin
                col_reg <= '0;
                row_reg <= flags.eof_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    nbs_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (LW_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    nbs_window #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_flags  (flags),
        .in_col    (col_reg),
        .in_row    (row_reg),
        .in_pixel  (pixel_eff),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (out_sum),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_tlast),
        .out_eof   (m_tuser)
    );

    // Pack the result word
    assign m_tdata = M_TDATA_W'({out_col, out_row, out_sum});

    // Frame end lands on the bottom right pixel and closes its run
    a_eof_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (out_col == width_last_reg)
                                 && (out_row == height_reg - ROW_W'(1)))
        else $error("end of frame away from the bottom right pixel");

    // Results stay inside the image
    a_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_col <= width_last_reg) && (out_row < height_reg))
        else $error("result position outside the image");

    // A result of the last column always closes its run
    a_edge_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_col == width_last_reg) |-> m_tlast)
        else $error("last column result without run end");

endmodule
